### rtl/bfre_pkg.sv
// shared constants, codes and controller/datapath interface types of the rectangle engine
package bfre_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int CELL_WIDTH    = 8;
    localparam int CELL_HEIGHT   = 16;

    localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);

    // field widths
    localparam int CMD_W = 2;
    localparam int X_W   = 7;
    localparam int Y_W   = 6;
    localparam int W_W   = 8;
    localparam int H_W   = 7;
    localparam int PIX_W = 8;
    localparam int ST_W  = 2;

    // width for on-screen arithmetic, wide enough for the sums on this screen
    localparam int CHK_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILL   = 2'd0,
        CMD_COPY   = 2'd1,
        CMD_CURSOR = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_DONE      = 2'd0,
        ST_DIAGONAL  = 2'd1,
        ST_OFFSCREEN = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic load;
        logic walk_init;
        logic walk_step;
        logic pix_read;
        logic res_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_status code;
        logic    work;
        logic    is_read;
        logic    walk_last;
        logic    clear_last;
    } t_dp_stat;

endpackage

### rtl/bfre_ctrl.sv
// sequencing state machine of the rectangle engine
module bfre_ctrl
    import bfre_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_READ,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.clear_en  = (r_state == S_CLEAR);
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.walk_init = (r_state == S_CHECK) && i_stat.work;
        o_cmd.walk_step = (r_state == S_WALK);
        o_cmd.pix_read  = (r_state == S_READ);
        o_cmd.res_load  = (r_state == S_RESP) && (!r_out_valid || i_out_ready);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_stat.clear_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    priority if (i_stat.work) r_state <= S_WALK;
                    else if (i_stat.is_read && i_stat.code == ST_DONE) r_state <= S_READ;
                    else r_state <= S_RESP;
                end
                S_WALK: begin
                    if (i_stat.walk_last) r_state <= S_RESP;
                end
                S_READ: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || i_out_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            if (o_cmd.res_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

endmodule

### rtl/bfre_dpath.sv
// frame store, rectangle walker, screen checks and result register
module bfre_dpath
    import bfre_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [CMD_W-1:0] i_command,
    input  logic [X_W-1:0]   i_left,
    input  logic [Y_W-1:0]   i_top,
    input  logic [W_W-1:0]   i_rect_width,
    input  logic [H_W-1:0]   i_rect_height,
    input  logic [X_W-1:0]   i_dest_left,
    input  logic [Y_W-1:0]   i_dest_top,
    input  logic [PIX_W-1:0] i_color,
    input  logic [PIX_W-1:0] i_other_color,
    output t_dp_stat         o_stat,
    output logic [PIX_W-1:0] o_read_data,
    output logic [ST_W-1:0]  o_status
);

    logic [PIX_W-1:0] mem [STORE_SIZE];

    // latched command
    t_cmd             r_cmd;
    logic [X_W-1:0]   r_left, r_dleft;
    logic [Y_W-1:0]   r_top, r_dtop;
    logic [W_W-1:0]   r_w;
    logic [H_W-1:0]   r_h;
    logic [PIX_W-1:0] r_color, r_mask;

    // walker
    logic [X_W-1:0] r_sx0, r_dx0, r_sx, r_dx;
    logic [Y_W-1:0] r_sy, r_dy;
    logic           r_xdec, r_ydec;
    logic [W_W-1:0] r_weff, r_col;
    logic [H_W-1:0] r_heff, r_row;

    // write stage and clearing sweep
    logic              r_wr_en;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [PIX_W-1:0]  r_rd_data;

    t_status          r_res_status;
    logic [PIX_W-1:0] r_res_data;

    logic src_fit, dst_fit, cur_fit, pix_in, empty, diag, same;
    logic col_end, row_end;
    logic n_xdec, n_ydec, is_copy, is_cursor;
    logic [W_W-1:0] n_weff;
    logic [H_W-1:0] n_heff;
    logic [X_W-1:0] n_dbase_x;
    logic [Y_W-1:0] n_dbase_y;
    logic [ADDR_W-1:0] src_addr, dst_addr, pix_addr, rd_addr;
    logic [PIX_W-1:0]  wr_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= t_cmd'(i_command);
            r_left  <= i_left;
            r_top   <= i_top;
            r_w     <= i_rect_width;
            r_h     <= i_rect_height;
            r_dleft <= i_dest_left;
            r_dtop  <= i_dest_top;
            r_color <= i_color;
            r_mask  <= i_color ^ i_other_color;
        end
    end

    // screen checks on the latched command
    always_comb begin
        src_fit = (CHK_W'(r_left) + CHK_W'(r_w) <= CHK_W'(SCREEN_WIDTH))
               && (CHK_W'(r_top) + CHK_W'(r_h) <= CHK_W'(SCREEN_HEIGHT));
        dst_fit = (CHK_W'(r_dleft) + CHK_W'(r_w) <= CHK_W'(SCREEN_WIDTH))
               && (CHK_W'(r_dtop) + CHK_W'(r_h) <= CHK_W'(SCREEN_HEIGHT));
        cur_fit = (CHK_W'(r_left) + CHK_W'(CELL_WIDTH) <= CHK_W'(SCREEN_WIDTH))
               && (CHK_W'(r_top) + CHK_W'(CELL_HEIGHT) <= CHK_W'(SCREEN_HEIGHT));
        pix_in  = (CHK_W'(r_left) < CHK_W'(SCREEN_WIDTH))
               && (CHK_W'(r_top) < CHK_W'(SCREEN_HEIGHT));
        empty   = (r_w == '0) || (r_h == '0);
        diag    = (r_left != r_dleft) && (r_top != r_dtop);
        same    = (r_left == r_dleft) && (r_top == r_dtop);

        o_stat      = '0;
        o_stat.code = ST_DONE;
        unique case (r_cmd)
            CMD_FILL: begin
                o_stat.code = src_fit ? ST_DONE : ST_OFFSCREEN;
                o_stat.work = src_fit && !empty;
            end
            CMD_COPY: begin
                priority if (!(src_fit && dst_fit)) o_stat.code = ST_OFFSCREEN;
                else if (diag) o_stat.code = ST_DIAGONAL;
                else o_stat.code = ST_DONE;
                o_stat.work = src_fit && dst_fit && !diag && !same && !empty;
            end
            CMD_CURSOR: begin
                o_stat.code = cur_fit ? ST_DONE : ST_OFFSCREEN;
                o_stat.work = cur_fit;
            end
            CMD_READ: begin
                o_stat.code = pix_in ? ST_DONE : ST_OFFSCREEN;
            end
        endcase
        o_stat.is_read    = (r_cmd == CMD_READ);
        o_stat.walk_last  = col_end && row_end;
        o_stat.clear_last = (r_clr_addr == ADDR_W'(STORE_SIZE - 1));
    end

    // walk set-up: copies towards higher addresses run backwards
    always_comb begin
        is_copy   = (r_cmd == CMD_COPY);
        is_cursor = (r_cmd == CMD_CURSOR);
        n_xdec    = is_copy && (r_dleft > r_left);
        n_ydec    = is_copy && (r_dtop > r_top);
        n_weff    = is_cursor ? W_W'(CELL_WIDTH) : r_w;
        n_heff    = is_cursor ? H_W'(CELL_HEIGHT) : r_h;
        n_dbase_x = is_copy ? r_dleft : r_left;
        n_dbase_y = is_copy ? r_dtop : r_top;
    end

    assign col_end = (r_col == W_W'(r_weff - 1'b1));
    assign row_end = (r_row == H_W'(r_heff - 1'b1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_xdec <= n_xdec;
            r_ydec <= n_ydec;
            r_weff <= n_weff;
            r_heff <= n_heff;
            r_col  <= '0;
            r_row  <= '0;
            if (n_xdec) begin
                r_sx0 <= X_W'(CHK_W'(r_left) + CHK_W'(n_weff) - 1'b1);
                r_dx0 <= X_W'(CHK_W'(n_dbase_x) + CHK_W'(n_weff) - 1'b1);
                r_sx  <= X_W'(CHK_W'(r_left) + CHK_W'(n_weff) - 1'b1);
                r_dx  <= X_W'(CHK_W'(n_dbase_x) + CHK_W'(n_weff) - 1'b1);
            end else begin
                r_sx0 <= r_left;
                r_dx0 <= n_dbase_x;
                r_sx  <= r_left;
                r_dx  <= n_dbase_x;
            end
            if (n_ydec) begin
                r_sy <= Y_W'(CHK_W'(r_top) + CHK_W'(n_heff) - 1'b1);
                r_dy <= Y_W'(CHK_W'(n_dbase_y) + CHK_W'(n_heff) - 1'b1);
            end else begin
                r_sy <= r_top;
                r_dy <= n_dbase_y;
            end
        end else if (i_cmd.walk_step) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
                r_sx  <= r_sx0;
                r_dx  <= r_dx0;
                if (r_ydec) begin
                    r_sy <= r_sy - 1'b1;
                    r_dy <= r_dy - 1'b1;
                end else begin
                    r_sy <= r_sy + 1'b1;
                    r_dy <= r_dy + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
                if (r_xdec) begin
                    r_sx <= r_sx - 1'b1;
                    r_dx <= r_dx - 1'b1;
                end else begin
                    r_sx <= r_sx + 1'b1;
                    r_dx <= r_dx + 1'b1;
                end
            end
        end
    end

    assign src_addr = ADDR_W'(ADDR_W'(r_sy) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(r_sx);
    assign dst_addr = ADDR_W'(ADDR_W'(r_dy) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(r_dx);
    assign pix_addr = ADDR_W'(ADDR_W'(r_top) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(r_left);
    assign rd_addr  = i_cmd.pix_read ? pix_addr : src_addr;

    // read one step ahead of the write, the walk order keeps overlaps safe
    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_read || i_cmd.walk_step) r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        unique case (r_cmd)
            CMD_FILL:   wr_data = r_color;
            CMD_COPY:   wr_data = r_rd_data;
            CMD_CURSOR: wr_data = r_rd_data ^ r_mask;
            CMD_READ:   wr_data = r_rd_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= dst_addr;
        if (!i_rst_n) begin
            r_wr_en    <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            r_wr_en <= i_cmd.walk_step;
            if (i_cmd.clear_en) r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) mem[r_clr_addr] <= '0;
        else if (r_wr_en) mem[r_wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= o_stat.code;
            r_res_data   <= (o_stat.is_read && o_stat.code == ST_DONE) ? r_rd_data : '0;
        end
    end

    assign o_read_data = r_res_data;
    assign o_status    = r_res_status;

endmodule

### rtl/byte_framebuffer_rect_engine_unit.sv
// top level of the byte frame store rectangle engine
//
//  channel   direction  handshake                   payload
//  command   in         i_in_valid / o_in_ready     i_command .. i_other_color
//  result    out        o_out_valid / i_out_ready   o_read_data, o_status
//
// after reset a clearing sweep zeroes the frame store, one pixel a cycle,
// over all 128 x 64 pixels of the screen, with no command taken meanwhile
// fill and copy walk each rectangle pixel, cursor its cell_width x cell_height
// cell, read fetches one pixel, and ignored or empty commands skip the walk;
// the single frame store write port, one pixel per cycle, sets the walk time
// a finished result sits in the output register; the next command is taken
// while it waits, but its own result stalls until the register is free
module byte_framebuffer_rect_engine_unit
    import bfre_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // command channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CMD_W-1:0] i_command,
    input  logic [X_W-1:0]   i_left,
    input  logic [Y_W-1:0]   i_top,
    input  logic [W_W-1:0]   i_rect_width,
    input  logic [H_W-1:0]   i_rect_height,
    input  logic [X_W-1:0]   i_dest_left,
    input  logic [Y_W-1:0]   i_dest_top,
    input  logic [PIX_W-1:0] i_color,
    input  logic [PIX_W-1:0] i_other_color,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [PIX_W-1:0] o_read_data,
    output logic [ST_W-1:0]  o_status
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing: clear sweep, check, walk or single read, result hand-off
    bfre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // frame store with its address walker and the result register
    bfre_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_command     (i_command),
        .i_left        (i_left),
        .i_top         (i_top),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_dest_left   (i_dest_left),
        .i_dest_top    (i_dest_top),
        .i_color       (i_color),
        .i_other_color (i_other_color),
        .o_stat        (dp_stat),
        .o_read_data   (o_read_data),
        .o_status      (o_status)
    );

`ifndef SYNTHESIS
    // the clearing sweep and a walk never share the write port
    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_cmd.clear_en && (dp_cmd.walk_step || dp_cmd.load)))
        else $error("clear sweep overlaps command work");

    // one command in flight: no second transfer straight after a transfer
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("command taken while previous one is in progress");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.res_load |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

    // a result transfer without a new load empties the output register
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !dp_cmd.res_load) |=> !o_out_valid)
        else $error("result repeated after transfer");
`endif

endmodule
